// ===== hw/rtl/sbwd_pkg.sv =====
// shared types and constants of the spi bus word decoder
// no dependencies

package sbwd_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 7;
  localparam int WORD_OUT_BITS  = 64;
  localparam int STAMP_OUT_BITS = 48;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BITS_PER_WORD       = 3'd0,
    REG_MSB_FIRST           = 3'd1,
    REG_CLOCK_IDLE_LEVEL    = 3'd2,
    REG_SAMPLE_ON_TRAILING  = 3'd3,
    REG_ENABLE_ACTIVE_LEVEL = 3'd4,
    REG_ENABLE_PRESENT      = 3'd5,
    REG_MOSI_PRESENT        = 3'd6,
    REG_MISO_PRESENT        = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [6:0] bits_per_word;
    logic       msb_first;
    logic       clock_idle_level;
    logic       sample_on_trailing;
    logic       enable_active_level;
    logic       enable_present;
    logic       mosi_present;
    logic       miso_present;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    bits_per_word:       7'd8,
    msb_first:           1'b1,
    clock_idle_level:    1'b0,
    sample_on_trailing:  1'b0,
    enable_active_level: 1'b0,
    enable_present:      1'b1,
    mosi_present:        1'b1,
    miso_present:        1'b1
  };

  typedef struct packed {
    logic clock_level;
    logic mosi_level;
    logic miso_level;
    logic enable_level;
  } sample_t;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'b001,
    PH_ACTIVE = 3'b010,
    PH_ERROR  = 3'b100
  } phase_t;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

endpackage

// ===== hw/rtl/spi_bus_word_decoder.sv =====
// top level of the spi bus word decoder: input register, decode engine, result register
// depends on sbwd_pkg, sbwd_cfg and sbwd_engine

// Passive SPI monitor. Each request on the input channel is one sample of the clock,
// MOSI, MISO and chip-enable lines; samples are numbered from zero and the number
// wraps at SAMPLE_BITS bits. A data frame (kind 0) carries the MOSI and MISO words and
// the sample numbers of the first and last clock edge of the word; an error frame
// (kind 1) marks a clock that was not idle when enable went active and spans the
// activation and release samples. Throughput is one sample per clock when the input
// is not stalled; a sample passes the input register, then the single-pass state
// update writes its result into the result register. The input stalls only while a
// result is held on a stalled output and the sample in the input register would give
// another one. There is no clearing pass after reset.

module spi_bus_word_decoder #(
  parameter int SAMPLE_BITS   = 48,
  parameter int MAX_WORD_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbwd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sbwd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                clock_level,
  input  logic                                mosi_level,
  input  logic                                miso_level,
  input  logic                                enable_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                kind,
  output logic [sbwd_pkg::WORD_OUT_BITS-1:0]  mosi_data,
  output logic [sbwd_pkg::WORD_OUT_BITS-1:0]  miso_data,
  output logic [sbwd_pkg::STAMP_OUT_BITS-1:0] start_sample,
  output logic [sbwd_pkg::STAMP_OUT_BITS-1:0] end_sample
);

  sbwd_pkg::cfg_t           cfg;
  sbwd_pkg::sample_t        smp;
  logic                     smp_valid;
  logic                     accept;
  logic                     process;
  logic                     emit;
  logic                     res_kind;
  logic [MAX_WORD_BITS-1:0] res_mosi, res_miso;
  logic [SAMPLE_BITS-1:0]   res_start, res_end;

  sbwd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sbwd_engine #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .MAX_WORD_BITS (MAX_WORD_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (process),
    .smp       (smp),
    .emit      (emit),
    .res_kind  (res_kind),
    .res_mosi  (res_mosi),
    .res_miso  (res_miso),
    .res_start (res_start),
    .res_end   (res_end)
  );

  // a sample with no result never waits on the output
  assign process  = smp_valid && (!emit || !out_valid || !out_stall);
  assign in_stall = smp_valid && !process;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (accept) begin
      smp_valid <= 1'b1;
    end else if (process) begin
      smp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp <= '{clock_level:  clock_level,
               mosi_level:   mosi_level,
               miso_level:   miso_level,
               enable_level: enable_level};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process && emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && emit) begin
      kind         <= res_kind;
      mosi_data    <= sbwd_pkg::WORD_OUT_BITS'(res_mosi);
      miso_data    <= sbwd_pkg::WORD_OUT_BITS'(res_miso);
      start_sample <= sbwd_pkg::STAMP_OUT_BITS'(res_start);
      end_sample   <= sbwd_pkg::STAMP_OUT_BITS'(res_end);
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(process && emit))
    else $error("result register overwritten while stalled");

  a_error_words_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == sbwd_pkg::KIND_ERROR) |-> (mosi_data == '0 && miso_data == '0))
    else $error("error frame with nonzero words");

  a_result_from_sample: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(process))
    else $error("result without a processed sample");

  a_take_needs_room: assert property (@(posedge clk) disable iff (rst)
    accept |=> smp_valid)
    else $error("accepted sample lost");

endmodule

// ===== hw/rtl/sbwd_cfg.sv =====
// configuration register file of the spi bus word decoder
// depends on sbwd_pkg

module sbwd_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sbwd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sbwd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output sbwd_pkg::cfg_t                     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= sbwd_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sbwd_pkg::cfg_idx_t'(cfg_index))
        sbwd_pkg::REG_BITS_PER_WORD:       cfg.bits_per_word <= cfg_data;
        sbwd_pkg::REG_MSB_FIRST:           cfg.msb_first <= cfg_data[0];
        sbwd_pkg::REG_CLOCK_IDLE_LEVEL:    cfg.clock_idle_level <= cfg_data[0];
        sbwd_pkg::REG_SAMPLE_ON_TRAILING:  cfg.sample_on_trailing <= cfg_data[0];
        sbwd_pkg::REG_ENABLE_ACTIVE_LEVEL: cfg.enable_active_level <= cfg_data[0];
        sbwd_pkg::REG_ENABLE_PRESENT:      cfg.enable_present <= cfg_data[0];
        sbwd_pkg::REG_MOSI_PRESENT:        cfg.mosi_present <= cfg_data[0];
        sbwd_pkg::REG_MISO_PRESENT:        cfg.miso_present <= cfg_data[0];
      endcase
    end
  end

endmodule

// ===== hw/rtl/sbwd_engine.sv =====
// decode state and single-pass next-state logic of the spi bus word decoder
// depends on sbwd_pkg

module sbwd_engine #(
  parameter int SAMPLE_BITS   = 48,
  parameter int MAX_WORD_BITS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sbwd_pkg::cfg_t           cfg,
  input  logic                     step,
  input  sbwd_pkg::sample_t        smp,
  output logic                     emit,
  output logic                     res_kind,
  output logic [MAX_WORD_BITS-1:0] res_mosi,
  output logic [MAX_WORD_BITS-1:0] res_miso,
  output logic [SAMPLE_BITS-1:0]   res_start,
  output logic [SAMPLE_BITS-1:0]   res_end
);

  localparam int IW = $clog2(MAX_WORD_BITS);
  localparam logic [6:0] MAX_W = 7'(MAX_WORD_BITS);

  sbwd_pkg::phase_t         phase, phase_next;
  logic [6:0]               bit_count, bit_count_next;
  logic [MAX_WORD_BITS-1:0] mosi_shift, mosi_shift_next;
  logic [MAX_WORD_BITS-1:0] miso_shift, miso_shift_next;
  logic                     prev_clock, prev_enable;
  logic [SAMPLE_BITS-1:0]   sample_count;
  logic [SAMPLE_BITS-1:0]   frame_start, frame_start_next;
  logic [SAMPLE_BITS-1:0]   last_edge_sample, last_edge_next;
  logic                     awaiting_trailing, awaiting_next;

  logic [6:0]               wb;
  logic [6:0]               bc1;
  logic [IW-1:0]            idx;
  logic [MAX_WORD_BITS-1:0] mosi_ins, miso_ins, mosi_add, miso_add;
  logic                     active, leading, take;

  always_comb begin
    if (cfg.bits_per_word == 7'd0) begin
      wb = 7'd1;
    end else if (cfg.bits_per_word > MAX_W) begin
      wb = MAX_W;
    end else begin
      wb = cfg.bits_per_word;
    end
  end

  assign bc1     = bit_count + 7'd1;
  assign idx     = bit_count[IW-1:0];
  assign active  = (smp.enable_level == cfg.enable_active_level);
  assign leading = (smp.clock_level != cfg.clock_idle_level);
  assign take    = (leading != cfg.sample_on_trailing);

  // lsb first places the bit at the current count
  always_comb begin
    mosi_ins      = mosi_shift;
    miso_ins      = miso_shift;
    mosi_ins[idx] = mosi_shift[idx] | smp.mosi_level;
    miso_ins[idx] = miso_shift[idx] | smp.miso_level;
  end

  always_comb begin
    if (!cfg.mosi_present) begin
      mosi_add = mosi_shift;
    end else if (cfg.msb_first) begin
      mosi_add = {mosi_shift[MAX_WORD_BITS-2:0], smp.mosi_level};
    end else begin
      mosi_add = mosi_ins;
    end
    if (!cfg.miso_present) begin
      miso_add = miso_shift;
    end else if (cfg.msb_first) begin
      miso_add = {miso_shift[MAX_WORD_BITS-2:0], smp.miso_level};
    end else begin
      miso_add = miso_ins;
    end
  end

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    mosi_shift_next  = mosi_shift;
    miso_shift_next  = miso_shift;
    frame_start_next = frame_start;
    last_edge_next   = last_edge_sample;
    awaiting_next    = awaiting_trailing;
    emit             = 1'b0;
    res_kind         = sbwd_pkg::KIND_DATA;
    res_mosi         = mosi_shift;
    res_miso         = miso_shift;
    res_start        = frame_start;
    res_end          = sample_count;
    unique case (phase)
      sbwd_pkg::PH_ACTIVE: begin
        if (cfg.enable_present && !active) begin
          // release: a word still waiting for its trailing edge goes out
          if (awaiting_trailing) begin
            emit    = 1'b1;
            res_end = last_edge_sample;
          end
          bit_count_next  = '0;
          mosi_shift_next = '0;
          miso_shift_next = '0;
          awaiting_next   = 1'b0;
          phase_next      = sbwd_pkg::PH_WAIT;
        end else if (smp.clock_level != prev_clock) begin
          if (awaiting_trailing) begin
            emit            = 1'b1;
            bit_count_next  = '0;
            mosi_shift_next = '0;
            miso_shift_next = '0;
            awaiting_next   = 1'b0;
          end else begin
            if (leading && bit_count == 7'd0) begin
              frame_start_next = sample_count;
            end
            last_edge_next = sample_count;
            if (take) begin
              if (bc1 >= wb) begin
                if (leading) begin
                  awaiting_next   = 1'b1;
                  bit_count_next  = bc1;
                  mosi_shift_next = mosi_add;
                  miso_shift_next = miso_add;
                end else begin
                  emit            = 1'b1;
                  res_mosi        = mosi_add;
                  res_miso        = miso_add;
                  bit_count_next  = '0;
                  mosi_shift_next = '0;
                  miso_shift_next = '0;
                end
              end else begin
                bit_count_next  = bc1;
                mosi_shift_next = mosi_add;
                miso_shift_next = miso_add;
              end
            end
          end
        end
      end
      sbwd_pkg::PH_ERROR: begin
        res_kind = sbwd_pkg::KIND_ERROR;
        res_mosi = '0;
        res_miso = '0;
        if (!cfg.enable_present) begin
          phase_next = sbwd_pkg::PH_WAIT;
        end else if (!active) begin
          emit       = 1'b1;
          phase_next = sbwd_pkg::PH_WAIT;
        end
      end
      default: begin
        phase_next = sbwd_pkg::PH_WAIT;
        if (cfg.enable_present) begin
          if (active && prev_enable != cfg.enable_active_level) begin
            frame_start_next = sample_count;
            bit_count_next   = '0;
            mosi_shift_next  = '0;
            miso_shift_next  = '0;
            awaiting_next    = 1'b0;
            phase_next       = leading ? sbwd_pkg::PH_ERROR : sbwd_pkg::PH_ACTIVE;
          end
        end else if (!leading) begin
          bit_count_next  = '0;
          mosi_shift_next = '0;
          miso_shift_next = '0;
          awaiting_next   = 1'b0;
          phase_next      = sbwd_pkg::PH_ACTIVE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= sbwd_pkg::PH_WAIT;
      bit_count         <= '0;
      mosi_shift        <= '0;
      miso_shift        <= '0;
      prev_clock        <= sbwd_pkg::CFG_RESET.clock_idle_level;
      prev_enable       <= ~sbwd_pkg::CFG_RESET.enable_active_level;
      sample_count      <= '0;
      frame_start       <= '0;
      last_edge_sample  <= '0;
      awaiting_trailing <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      bit_count         <= bit_count_next;
      mosi_shift        <= mosi_shift_next;
      miso_shift        <= miso_shift_next;
      prev_clock        <= smp.clock_level;
      prev_enable       <= smp.enable_level;
      sample_count      <= sample_count + SAMPLE_BITS'(1);
      frame_start       <= frame_start_next;
      last_edge_sample  <= last_edge_next;
      awaiting_trailing <= awaiting_next;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench of spi_bus_word_decoder: a frame tracker predicts data and
// error frames from accepted samples and checks every frame the block puts out
// depends on sbwd_pkg and spi_bus_word_decoder

module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int NUM_SETTINGS   = 13;

  typedef logic [sbwd_pkg::WORD_OUT_BITS-1:0]  word_t;
  typedef logic [sbwd_pkg::STAMP_OUT_BITS-1:0] stamp_t;

  typedef struct {
    logic   kind;
    word_t  mosi;
    word_t  miso;
    stamp_t start_at;
    stamp_t end_at;
  } frame_t;

  class spi_frame_tracker;
    sbwd_pkg::cfg_t   regs;
    sbwd_pkg::phase_t state;
    logic [6:0]       bit_cnt;
    word_t            mosi_acc;
    word_t            miso_acc;
    logic             prev_clk;
    logic             prev_en;
    logic             await_trail;
    stamp_t           sample_no;
    stamp_t           word_start;
    stamp_t           last_edge;
    frame_t           frames_due[$];
    int               fails;
    int               data_seen;
    int               error_seen;

    function new();
      regs = sbwd_pkg::CFG_RESET;
      state = sbwd_pkg::PH_WAIT;
      clear_word();
      prev_clk = regs.clock_idle_level;
      prev_en = ~regs.enable_active_level;
      sample_no = '0;
      word_start = '0;
      last_edge = '0;
      fails = 0;
      data_seen = 0;
      error_seen = 0;
    endfunction

    function void clear_word();
      bit_cnt = '0;
      mosi_acc = '0;
      miso_acc = '0;
      await_trail = 1'b0;
    endfunction

    function word_t add_bit(word_t w, logic b);
      if (regs.msb_first) return {w[sbwd_pkg::WORD_OUT_BITS-2:0], b};
      return w | (sbwd_pkg::WORD_OUT_BITS'(b) << bit_cnt[5:0]);
    endfunction

    function void push_frame(logic k, word_t mo, word_t mi, stamp_t s, stamp_t e);
      frame_t f;
      f.kind = k;
      f.mosi = mo;
      f.miso = mi;
      f.start_at = s;
      f.end_at = e;
      frames_due = {frames_due, f};
    endfunction

    function void write_reg(sbwd_pkg::cfg_idx_t idx, logic [sbwd_pkg::CFG_DATA_BITS-1:0] d);
      case (idx)
        sbwd_pkg::REG_BITS_PER_WORD:       regs.bits_per_word = d;
        sbwd_pkg::REG_MSB_FIRST:           regs.msb_first = d[0];
        sbwd_pkg::REG_CLOCK_IDLE_LEVEL:    regs.clock_idle_level = d[0];
        sbwd_pkg::REG_SAMPLE_ON_TRAILING:  regs.sample_on_trailing = d[0];
        sbwd_pkg::REG_ENABLE_ACTIVE_LEVEL: regs.enable_active_level = d[0];
        sbwd_pkg::REG_ENABLE_PRESENT:      regs.enable_present = d[0];
        sbwd_pkg::REG_MOSI_PRESENT:        regs.mosi_present = d[0];
        sbwd_pkg::REG_MISO_PRESENT:        regs.miso_present = d[0];
        default: ;
      endcase
    endfunction

    function void take_sample(sbwd_pkg::sample_t s);
      logic sel;
      logic lead;
      logic take;
      int   need;
      sel = (s.enable_level == regs.enable_active_level);
      need = (regs.bits_per_word == 0) ? 1 :
             (regs.bits_per_word > 64) ? 64 : int'(regs.bits_per_word);
      case (state)
        sbwd_pkg::PH_ACTIVE: begin
          if (regs.enable_present && !sel) begin
            // release: a complete word still waiting for its trailing edge goes out
            if (await_trail)
              push_frame(sbwd_pkg::KIND_DATA, mosi_acc, miso_acc, word_start, last_edge);
            clear_word();
            state = sbwd_pkg::PH_WAIT;
          end else if (s.clock_level != prev_clk) begin
            lead = (s.clock_level != regs.clock_idle_level);
            if (await_trail) begin
              push_frame(sbwd_pkg::KIND_DATA, mosi_acc, miso_acc, word_start, sample_no);
              clear_word();
            end else begin
              take = lead ? !regs.sample_on_trailing : regs.sample_on_trailing;
              if (lead && bit_cnt == 0) word_start = sample_no;
              last_edge = sample_no;
              if (take) begin
                if (regs.mosi_present) mosi_acc = add_bit(mosi_acc, s.mosi_level);
                if (regs.miso_present) miso_acc = add_bit(miso_acc, s.miso_level);
                bit_cnt++;
                if (bit_cnt >= need) begin
                  if (lead) begin
                    await_trail = 1'b1;
                  end else begin
                    push_frame(sbwd_pkg::KIND_DATA, mosi_acc, miso_acc, word_start,
                               sample_no);
                    clear_word();
                  end
                end
              end
            end
          end
        end
        sbwd_pkg::PH_ERROR: begin
          if (!regs.enable_present) begin
            state = sbwd_pkg::PH_WAIT;
          end else if (!sel) begin
            push_frame(sbwd_pkg::KIND_ERROR, '0, '0, word_start, sample_no);
            state = sbwd_pkg::PH_WAIT;
          end
        end
        default: begin
          if (regs.enable_present) begin
            if (sel && prev_en != regs.enable_active_level) begin
              word_start = sample_no;
              clear_word();
              if (s.clock_level == regs.clock_idle_level) state = sbwd_pkg::PH_ACTIVE;
              else state = sbwd_pkg::PH_ERROR;
            end else begin
              state = sbwd_pkg::PH_WAIT;
            end
          end else if (s.clock_level == regs.clock_idle_level) begin
            clear_word();
            state = sbwd_pkg::PH_ACTIVE;
          end else begin
            state = sbwd_pkg::PH_WAIT;
          end
        end
      endcase
      prev_clk = s.clock_level;
      prev_en = s.enable_level;
      sample_no++;
    endfunction

    task report(string msg);
      fails++;
      if (fails <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_frame(frame_t got);
      frame_t want;
      if (frames_due.size() == 0) begin
        report($sformatf("frame with nothing due: kind %0d mosi %h miso %h span %0d..%0d",
                         got.kind, got.mosi, got.miso, got.start_at, got.end_at));
        return;
      end
      want = frames_due.pop_front();
      if (want.kind == sbwd_pkg::KIND_ERROR) error_seen++;
      else data_seen++;
      if (got.kind !== want.kind)
        report($sformatf("kind: got %0d want %0d", got.kind, want.kind));
      if (got.mosi !== want.mosi)
        report($sformatf("mosi_data: got %h want %h", got.mosi, want.mosi));
      if (got.miso !== want.miso)
        report($sformatf("miso_data: got %h want %h", got.miso, want.miso));
      if (got.start_at !== want.start_at)
        report($sformatf("start_sample: got %0d want %0d", got.start_at, want.start_at));
      if (got.end_at !== want.end_at)
        report($sformatf("end_sample: got %0d want %0d", got.end_at, want.end_at));
    endtask
  endclass

  logic                                clk;
  logic                                rst;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [sbwd_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [sbwd_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic                                clock_level;
  logic                                mosi_level;
  logic                                miso_level;
  logic                                enable_level;
  logic                                out_valid;
  logic                                out_stall;
  logic                                kind;
  word_t                               mosi_data;
  word_t                               miso_data;
  stamp_t                              start_sample;
  stamp_t                              end_sample;

  spi_frame_tracker sb = new();
  sbwd_pkg::cfg_t   setting;
  frame_t           got_frame;
  int               quiet_cycles = 0;
  int               sent_count = 0;
  int               phase_sent = 0;
  int               settings_run = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_left = 0;
  bit               hold_req = 1'b0;

  spi_bus_word_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .clock_level  (clock_level),
    .mosi_level   (mosi_level),
    .miso_level   (miso_level),
    .enable_level (enable_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .mosi_data    (mosi_data),
    .miso_data    (miso_data),
    .start_sample (start_sample),
    .end_sample   (end_sample)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stall, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got_frame.kind = kind;
        got_frame.mosi = mosi_data;
        got_frame.miso = miso_data;
        got_frame.start_at = start_sample;
        got_frame.end_at = end_sample;
        sb.check_frame(got_frame);
      end
      if (in_valid && !in_stall)
        sb.take_sample(sbwd_pkg::sample_t'({clock_level, mosi_level, miso_level,
                                            enable_level}));
      if (cfg_valid && cfg_ready) sb.write_reg(sbwd_pkg::cfg_idx_t'(cfg_index), cfg_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // one request on the sample channel
  task send_sample(logic c, logic mo, logic mi, logic e);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    clock_level <= c;
    mosi_level <= mo;
    miso_level <= mi;
    enable_level <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    phase_sent++;
  endtask

  task line_sample(logic c, logic e);
    send_sample(c, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), e);
  endtask

  task write_reg(sbwd_pkg::cfg_idx_t idx, logic [sbwd_pkg::CFG_DATA_BITS-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task apply_setting(sbwd_pkg::cfg_t c);
    settle();
    write_reg(sbwd_pkg::REG_BITS_PER_WORD, c.bits_per_word);
    write_reg(sbwd_pkg::REG_MSB_FIRST, {6'($urandom), c.msb_first});
    write_reg(sbwd_pkg::REG_CLOCK_IDLE_LEVEL, {6'($urandom), c.clock_idle_level});
    write_reg(sbwd_pkg::REG_SAMPLE_ON_TRAILING, {6'($urandom), c.sample_on_trailing});
    write_reg(sbwd_pkg::REG_ENABLE_ACTIVE_LEVEL, {6'($urandom), c.enable_active_level});
    write_reg(sbwd_pkg::REG_ENABLE_PRESENT, {6'($urandom), c.enable_present});
    write_reg(sbwd_pkg::REG_MOSI_PRESENT, {6'($urandom), c.mosi_present});
    write_reg(sbwd_pkg::REG_MISO_PRESENT, {6'($urandom), c.miso_present});
    @(negedge clk);
    cfg_valid <= 1'b0;
    setting = c;
    settings_run++;
  endtask

  // select, clock out words of edges, release; cut >= 0 stops after that many edges
  task spi_transfer(int words, int bits, int cut, int hold_max);
    logic idle;
    logic act;
    logic c;
    int   total;
    int   e;
    idle = setting.clock_idle_level;
    act = setting.enable_active_level;
    repeat ($urandom_range(1, 3)) line_sample(idle, ~act);
    repeat ($urandom_range(1, 2)) line_sample(idle, act);
    total = words * bits * 2;
    c = idle;
    for (e = 0; e < total; e++) begin
      if (cut >= 0 && e >= cut) break;
      c = ~c;
      repeat ($urandom_range(1, hold_max)) line_sample(c, act);
    end
    // release, sometimes together with a clock edge
    if ($urandom_range(0, 3) == 0) c = ~c;
    line_sample(c, ~act);
  endtask

  // select with the clock away from idle
  task bad_start(bit close);
    logic idle;
    logic act;
    idle = setting.clock_idle_level;
    act = setting.enable_active_level;
    line_sample(1'($urandom_range(0, 1)), ~act);
    line_sample(~idle, act);
    if (close) begin
      repeat ($urandom_range(0, 3)) line_sample(1'($urandom_range(0, 1)), act);
      line_sample(1'($urandom_range(0, 1)), ~act);
    end
  endtask

  task run_setting(sbwd_pkg::cfg_t c, int budget, bit squeeze, bit leave_error);
    int eff;
    int r;
    int w;
    int total;
    apply_setting(c);
    eff = (c.bits_per_word == 0) ? 1 : (c.bits_per_word > 64) ? 64 : int'(c.bits_per_word);
    phase_sent = 0;
    if (squeeze) hold_req = 1'b1;
    while (phase_sent < budget) begin
      r = $urandom_range(0, 99);
      w = (eff > 16) ? 1 : $urandom_range(1, 3);
      total = w * eff * 2;
      if (r < 60)
        spi_transfer(w, eff, -1, (eff > 16) ? 1 : 2);
      else if (r < 72)
        spi_transfer(w, eff,
                     $urandom_range(0, 1) ? total - 1 : int'($urandom_range(0, total - 1)),
                     (eff > 16) ? 1 : 2);
      else if (r < 84)
        bad_start(1'b1);
      else
        repeat ($urandom_range(1, 6))
          send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    if (leave_error) bad_start(1'b0);
  endtask

  initial begin
    sbwd_pkg::cfg_t c;
    int             budget;
    bit             squeeze;
    bit             leave_error;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = sbwd_pkg::REG_BITS_PER_WORD;
    cfg_data = '0;
    in_valid = 1'b0;
    clock_level = 1'b0;
    mosi_level = 1'b0;
    miso_level = 1'b0;
    enable_level = 1'b1;
    setting = sbwd_pkg::CFG_RESET;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset settings: select on the very first sample, one full word
    send_sample(1'b0, 1'b1, 1'b0, 1'b0);
    repeat (8) begin
      send_sample(1'b1, 1'b1, 1'b0, 1'b0);
      send_sample(1'b0, 1'b0, 1'b1, 1'b0);
    end
    send_sample(1'b0, 1'b0, 1'b0, 1'b1);
    // clock high at select, then release
    send_sample(1'b1, 1'b1, 1'b1, 1'b0);
    send_sample(1'b0, 1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 1'b1);
    // release in the middle of a word
    send_sample(1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1, 1'b0);
    send_sample(1'b0, 1'b1, 1'b1, 1'b1);

    for (int i = 0; i < NUM_SETTINGS; i++) begin
      if (i < 4) begin
        send_idle_pct = 32;
        recv_idle_pct = 59;
      end else if (i < 8) begin
        send_idle_pct = 59;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      budget = 35;
      squeeze = 1'b0;
      leave_error = 1'b0;
      c = sbwd_pkg::cfg_t'(14'($urandom));
      c.bits_per_word = 7'($urandom_range(1, 8));
      case (i)
        0: c = '{7'd1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        1: c = '{7'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
        2: begin
          c = '{7'd64, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
          budget = 150;
        end
        4: begin
          c = '{7'd127, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
          budget = 150;
          leave_error = 1'b1;
        end
        5: c = '{7'd3, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
        6: c = '{7'd5, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
        8: begin
          c = '{7'd1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
          squeeze = 1'b1;
        end
        12: c = '{7'd2, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
        default: ;
      endcase
      run_setting(c, budget, squeeze, leave_error);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.frames_due.size() != 0)
      sb.report($sformatf("%0d frames never came out", sb.frames_due.size()));

    $display("ran %0d samples through a directed opening and %0d register settings",
             sent_count, settings_run);
    $display("compared %0d data frames and %0d error frames, %0d mismatches",
             sb.data_seen, sb.error_seen, sb.fails);
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
